// ===== hdl/ple_pkg.sv =====
// Shared types and constants of the positional list engine.
package ple_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DEPTH_MAX = 1024;
    // Wide enough for any count or slot up to DEPTH_MAX.
    localparam int CNT_W     = $clog2(DEPTH_MAX + 1);
    localparam int GROUP     = 8;
    localparam int GI_W      = $clog2(GROUP);

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_FINAL
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t           op;
        logic [CNT_W-1:0]   slot;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] value;
    } cell_ctrl_t;

    // Registered partial result of one group of cells.
    typedef struct packed {
        logic signed [31:0] rd;
        logic               hit;
        logic [GI_W-1:0]    first;
    } grp_res_t;

endpackage

// ===== hdl/ple_req_if.sv =====
// Request channel: command beats into the engine.
interface ple_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [7:0]         position;
    logic signed [31:0] item_value;

    modport source (output valid, command, position, item_value, input ready);
    modport sink   (input valid, command, position, item_value, output ready);
endinterface

// ===== hdl/ple_rsp_if.sv =====
// Response channel: result beats out of the engine.
interface ple_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         found_position;
    logic [6:0]         length_now;

    modport source (output valid, status, read_value, found_position, length_now,
                    input ready);
    modport sink   (input valid, status, read_value, found_position, length_now,
                    output ready);
endinterface

// ===== hdl/ple_cell.sv =====
// One storage cell of the list chain: shifts with its neighbors, flags select and match.
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  ple_pkg::cell_ctrl_t    ctrl,
    input  logic signed [31:0]     left,
    input  logic signed [31:0]     right,
    output logic signed [31:0]     value,
    output logic                   sel,
    output logic                   match
);

    localparam logic [ple_pkg::CNT_W-1:0] MY_IDX = ple_pkg::CNT_W'(IDX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    assign value = value_reg;
    assign sel   = (ctrl.slot == MY_IDX);
    assign match = (MY_IDX < ctrl.count) && (value_reg == ctrl.value);

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            ple_pkg::OP_INSERT:
            begin
                if (MY_IDX > ctrl.slot)
                    value_next = left;
                else if (MY_IDX == ctrl.slot)
                    value_next = ctrl.value;
            end
            ple_pkg::OP_DELETE:
            begin
                if (MY_IDX >= ctrl.slot)
                    value_next = right;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/ple_group.sv =====
// First reduction level: read mux and first-match search over one group of cells.
module ple_group (
    input  logic                                     clk,
    input  logic                                     capture,
    input  logic [ple_pkg::GROUP-1:0]                sel,
    input  logic [ple_pkg::GROUP-1:0]                match,
    input  logic [ple_pkg::GROUP-1:0][31:0]          vals,
    output ple_pkg::grp_res_t                        res
);

    ple_pkg::grp_res_t res_reg;
    ple_pkg::grp_res_t res_next;

    assign res = res_reg;

    always_comb
    begin
        res_next.rd    = '0;
        res_next.hit   = |match;
        res_next.first = '0;
        for (int i = 0; i < ple_pkg::GROUP; i++)
        begin
            if (sel[i])
                res_next.rd = res_next.rd | vals[i];
        end
        for (int i = ple_pkg::GROUP - 1; i >= 0; i--)
        begin
            if (match[i])
                res_next.first = ple_pkg::GI_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            res_reg <= res_next;
    end

endmodule

// ===== hdl/positional_list_engine.sv =====
// Top level: positional list engine built as a chain of storage cells.
// Keeps an ordered list of up to DEPTH signed 32-bit values. One command is
// handled at a time and passes through the accept edge, an edge at which
// the cell chain shifts for insert or delete while each group of eight cells
// registers its read and match result, and an edge at which the group results
// are combined into the response register. A new command is accepted in the
// cycle after that, so no command is taken while another is in flight, and
// a stalled response holds the engine in its final step. All list reads go
// through the two-level registered group tree.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ple_req_if.sink       req,
    ple_rsp_if.source     rsp
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int NG  = (DEPTH + ple_pkg::GROUP - 1) / ple_pkg::GROUP;
    localparam int PAD = NG * ple_pkg::GROUP;
    localparam logic [ple_pkg::CNT_W-1:0] DEPTH_C = ple_pkg::CNT_W'(DEPTH);

    ple_pkg::state_t state_reg, state_next;

    logic [2:0]         cmd_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         st_reg, st_next;
    logic               rd_en_reg, rd_en_next;
    logic               loc_reg, loc_next;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_rd_reg;
    logic [6:0]         out_found_reg;
    logic [6:0]         out_len_reg;

    logic               accept;
    logic               capture;
    logic               finish;

    ple_pkg::cell_ctrl_t ctrl;
    logic [ple_pkg::CNT_W-1:0] pos_ext, cnt_ext;

    logic [DEPTH-1:0][31:0] vals;
    logic [DEPTH-1:0]       sel_vec;
    logic [DEPTH-1:0]       match_vec;
    logic [PAD-1:0][31:0]   vals_pad;
    logic [PAD-1:0]         sel_pad;
    logic [PAD-1:0]         match_pad;
    ple_pkg::grp_res_t      grp [NG];

    logic signed [31:0]        fin_rd;
    logic                      fin_hit;
    logic [ple_pkg::CNT_W-1:0] fin_pos;

    assign pos_ext = ple_pkg::CNT_W'(pos_reg);
    assign cnt_ext = ple_pkg::CNT_W'(count_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        capture    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = ple_pkg::S_GROUP;
            end
            ple_pkg::S_GROUP:
            begin
                capture    = 1'b1;
                state_next = ple_pkg::S_FINAL;
            end
            ple_pkg::S_FINAL:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    finish     = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    // Command decode: status, new length and the shift command for the chain
    always_comb
    begin
        st_next    = ple_pkg::ST_OK;
        count_next = count_reg;
        rd_en_next = 1'b0;
        loc_next   = 1'b0;
        ctrl.op    = ple_pkg::OP_HOLD;
        ctrl.slot  = pos_ext - ple_pkg::CNT_W'(1);
        ctrl.count = cnt_ext;
        ctrl.value = val_reg;
        case (cmd_reg)
            ple_pkg::CMD_INSERT:
            begin
                if (pos_reg == 8'd0)
                    st_next = ple_pkg::ST_RANGE;
                else if (cnt_ext >= DEPTH_C)
                    st_next = ple_pkg::ST_FULL;
                else
                begin
                    if (pos_ext > cnt_ext)
                        ctrl.slot = cnt_ext;
                    ctrl.op    = ple_pkg::OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            ple_pkg::CMD_DELETE:
            begin
                if (pos_reg == 8'd0 || pos_ext > cnt_ext)
                    st_next = ple_pkg::ST_RANGE;
                else
                begin
                    ctrl.op    = ple_pkg::OP_DELETE;
                    count_next = count_reg - CW'(1);
                    rd_en_next = 1'b1;
                end
            end
            ple_pkg::CMD_GET:
            begin
                if (pos_reg == 8'd0 || pos_ext > cnt_ext)
                    st_next = ple_pkg::ST_RANGE;
                else
                    rd_en_next = 1'b1;
            end
            ple_pkg::CMD_LOCATE:
            begin
                loc_next = 1'b1;
            end
            ple_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                st_next = ple_pkg::ST_RANGE;
            end
        endcase
        if (!capture)
            ctrl.op = ple_pkg::OP_HOLD;
    end

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] left_v, right_v;
        if (i == 0)
        begin : g_first
            assign left_v = ctrl.value;
        end
        else
        begin : g_mid
            assign left_v = vals[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = vals[i];
        end
        else
        begin : g_inner
            assign right_v = vals[i+1];
        end
        ple_cell #(.IDX(i)) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_v),
            .right (right_v),
            .value (vals[i]),
            .sel   (sel_vec[i]),
            .match (match_vec[i])
        );
    end

    for (genvar i = 0; i < PAD; i++)
    begin : g_pad
        if (i < DEPTH)
        begin : g_real
            assign vals_pad[i]  = vals[i];
            assign sel_pad[i]   = sel_vec[i];
            assign match_pad[i] = match_vec[i];
        end
        else
        begin : g_fill
            assign vals_pad[i]  = '0;
            assign sel_pad[i]   = 1'b0;
            assign match_pad[i] = 1'b0;
        end
    end

    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        ple_group u_group (
            .clk     (clk),
            .capture (capture),
            .sel     (sel_pad[g*ple_pkg::GROUP +: ple_pkg::GROUP]),
            .match   (match_pad[g*ple_pkg::GROUP +: ple_pkg::GROUP]),
            .vals    (vals_pad[g*ple_pkg::GROUP +: ple_pkg::GROUP]),
            .res     (grp[g])
        );
    end

    // Second reduction level over the group results
    always_comb
    begin
        fin_rd  = '0;
        fin_hit = 1'b0;
        fin_pos = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            fin_rd = fin_rd | grp[g].rd;
            if (grp[g].hit)
            begin
                fin_hit = 1'b1;
                fin_pos = ple_pkg::CNT_W'(g * ple_pkg::GROUP)
                        + ple_pkg::CNT_W'(grp[g].first) + ple_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (capture)
                count_reg <= count_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            pos_reg <= req.position;
            val_reg <= req.item_value;
        end
        if (capture)
        begin
            st_reg    <= st_next;
            rd_en_reg <= rd_en_next;
            loc_reg   <= loc_next;
        end
        if (finish)
        begin
            out_status_reg <= st_reg;
            out_rd_reg     <= rd_en_reg ? fin_rd : 32'sd0;
            out_found_reg  <= (loc_reg && fin_hit) ? fin_pos[6:0] : 7'd0;
            out_len_reg    <= 7'(count_reg);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_value     = out_rd_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.length_now     = out_len_reg;

    // At most one cell is addressed when groups capture
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> $onehot0(sel_vec))
        else $error("more than one cell selected");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ple_pkg::CNT_W'(count_reg) <= DEPTH_C)
        else $error("length above depth");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ple_pkg::S_FINAL))
        else $error("response beat without a finished command");

    a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ple_pkg::S_GROUP) |=> $stable(count_reg))
        else $error("length changed outside the update step");

endmodule
